>>> src/hts_pkg.sv
// shared types and constants of the header/type/sum frame parser
package hts_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE = 1'd1;
    localparam logic [7:0] HEADER_RESET = 8'h15;
    localparam logic [7:0] TYPE_RESET = 8'h11;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PAYLOAD_BYTES-1:0][7:0] payload;
        logic [31:0] number;
    } frame_t;

    typedef struct packed {
        logic valid;
        frame_t frame;
    } push_t;

    typedef struct packed {
        logic valid;
        frame_t frame;
    } head_t;

endpackage

>>> src/hts_if.sv
// stream interfaces for received bytes and payload results
interface hts_rx_if import hts_pkg::*;;
    logic valid;
    logic ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface hts_res_if import hts_pkg::*;;
    logic valid;
    logic ready;
    logic [7:0] payload_byte;
    logic [5:0] byte_position;
    logic last_byte;
    logic [31:0] frame_number;

    modport source (output valid, output payload_byte, output byte_position,
                    output last_byte, output frame_number, input ready);
    modport sink (input valid, input payload_byte, input byte_position,
                  input last_byte, input frame_number, output ready);
endinterface

>>> src/hts_front.sv
// front part: frame recognition, payload capture, checksum and frame count
module hts_front import hts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  q_full,
    output logic                  in_ready,
    output push_t                 push
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic [31:0]       count_reg, count_next;
    logic [7:0]        header_reg, type_reg;
    logic [PAYLOAD_BYTES-1:0][7:0] store_reg;

    logic beat, is_hdr, in_body, store_we, good;

    assign in_ready = !q_full;
    assign beat     = in_valid && in_ready;
    assign is_hdr   = (in_byte == header_reg);
    assign in_body  = (pos_reg < POS_W'(PAYLOAD_BYTES));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (beat)
        begin
            if (is_hdr)
            begin
                phase_next = PH_TYPE;
            end
            else
            begin
                case (phase_reg)
                    PH_TYPE: phase_next = (in_byte == type_reg) ? PH_BODY : PH_IDLE;
                    PH_BODY: phase_next = in_body ? PH_BODY : PH_IDLE;
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // datapath outputs of the phase machine
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        store_we   = 1'b0;
        good       = 1'b0;
        if (beat)
        begin
            if (is_hdr)
            begin
                pos_next = '0;
                sum_next = in_byte;
            end
            else
            begin
                pos_next = '0;
                case (phase_reg)
                    PH_TYPE:
                    begin
                        if (in_byte == type_reg)
                        begin
                            sum_next = sum_reg + in_byte;
                        end
                    end
                    PH_BODY:
                    begin
                        if (in_body)
                        begin
                            store_we = 1'b1;
                            sum_next = sum_reg + in_byte;
                            pos_next = pos_reg + POS_W'(1);
                        end
                        else if (sum_reg == in_byte)
                        begin
                            good       = 1'b1;
                            count_next = count_reg + 32'd1;
                        end
                    end
                    default:
                    begin
                        pos_next = '0;
                    end
                endcase
            end
        end
    end

    assign push.valid         = good;
    assign push.frame.payload = store_reg;
    assign push.frame.number  = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            header_reg <= HEADER_RESET;
            type_reg   <= TYPE_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADER: header_reg <= cfg_data[7:0];
                    CFG_TYPE:   type_reg   <= cfg_data[7:0];
                    default:    ;
                endcase
            end
        end
    end

    // payload capture, one entry per payload beat
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[pos_reg[IDX_W-1:0]] <= in_byte;
        end
    end

endmodule

>>> src/hts_queue.sv
// short queue of accepted frames between front and back
module hts_queue import hts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    frame_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_reg, rd_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.frame = entry_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (!push.valid && pop)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
            begin
                wr_reg <= (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_reg] <= push.frame;
        end
    end

endmodule

>>> src/hts_back.sv
// back part: plays one queued frame out as a burst of payload beats
module hts_back import hts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  head_t head,
    output logic  pop,
    hts_res_if.source res
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last, beat;

    assign last = (idx_reg == IDX_W'(PAYLOAD_BYTES - 1));
    assign beat = res.valid && res.ready;
    assign pop  = beat && last;

    assign res.valid         = head.valid;
    assign res.payload_byte  = head.frame.payload[idx_reg];
    assign res.byte_position = 6'(idx_reg);
    assign res.last_byte     = last;
    assign res.frame_number  = head.frame.number;

    always_comb
    begin
        idx_next = idx_reg;
        if (beat)
        begin
            idx_next = last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> src/header_type_sum_frame_parser.sv
// top level of the header/type/sum frame parser
//
//   port   dir   beat contents
//   rx     in    rx_byte, one received byte
//   res    out   payload_byte, byte_position, last_byte, frame_number
//   cfg    in    cfg_we / cfg_index / cfg_data, header and type values
//
// one received byte is taken every cycle while the frame queue has room.
// a good frame leaves as eight result beats from a two-frame queue, one per cycle
// while res is ready, and then a frame of eleven or more bytes never outruns them.
// rx stalls only when both queue slots hold frames not yet fully delivered.
// reset clears phase, sum, counters, queue and restores header 0x15 and type 0x11.
module header_type_sum_frame_parser import hts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hts_rx_if.sink                rx,
    hts_res_if.source             res
);

    push_t push;
    head_t head;
    logic  q_full;
    logic  pop;

    hts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (rx.valid),
        .in_byte   (rx.rx_byte),
        .q_full    (q_full),
        .in_ready  (rx.ready),
        .push      (push)
    );

    hts_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    hts_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

>>> src/hts_checker.sv
// port-level checks of the result burst, bound to the top level
module hts_checker import hts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  out_pos,
    input logic        out_last,
    input logic [31:0] out_number
);

    // a beat offered is not withdrawn
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_pos == 6'(PAYLOAD_BYTES - 1))
        else $error("last mark on wrong payload position");

    // within a burst the position steps and the frame number holds
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            out_valid && out_pos == $past(out_pos) + 6'd1 && $stable(out_number))
        else $error("burst broken before last beat");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid || out_pos == 6'd0)
        else $error("new burst does not start at position zero");

endmodule

bind header_type_sum_frame_parser hts_checker u_hts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_pos    (res.byte_position),
    .out_last   (res.last_byte),
    .out_number (res.frame_number)
);

>>> sim/tb_header_type_sum_frame_parser.sv
// self-checking testbench of the header/type/sum frame parser
module tb_header_type_sum_frame_parser import hts_pkg::*;;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BYTES = 18;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] pos;
        logic last;
        logic [31:0] num;
    } beat_t;

    // directed row: byte to send, and where obvious the beats and frame number it must yield
    typedef struct packed {
        logic [7:0] value;
        logic typed;
        logic [3:0] beats;
        logic [31:0] num;
    } row_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_WRONG_TYPE,
        FR_HDR_IN_BODY,
        FR_HDR_IN_SUM,
        FR_NOISE
    } frame_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hts_rx_if rx_ch();
    hts_res_if res_ch();

    header_type_sum_frame_parser DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .rx(rx_ch),
        .res(res_ch)
    );

    always #5 clk = ~clk;

    // parser state as the testbench sees it
    logic [7:0] hdr_val = HEADER_RESET;
    logic [7:0] type_val = TYPE_RESET;
    phase_t ph = PH_IDLE;
    logic [6:0] body_cnt = '0;
    logic [7:0] run_sum = '0;
    logic [7:0] body_store [PAYLOAD_BYTES];
    logic [31:0] frames_ok = '0;

    beat_t expected_beats [$];
    int mismatches = 0;
    int bytes_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    row_t dir_rows [0:25] = '{
        '{8'hFF, 1'b1, 4'd0, 32'd0},
        '{8'h15, 1'b0, 4'd0, 32'd0},
        '{8'h15, 1'b0, 4'd0, 32'd0},
        '{8'h11, 1'b0, 4'd0, 32'd0},
        '{8'h00, 1'b0, 4'd0, 32'd0},
        '{8'hFF, 1'b0, 4'd0, 32'd0},
        '{8'h01, 1'b0, 4'd0, 32'd0},
        '{8'h80, 1'b0, 4'd0, 32'd0},
        '{8'h7F, 1'b0, 4'd0, 32'd0},
        '{8'h02, 1'b0, 4'd0, 32'd0},
        '{8'hFE, 1'b0, 4'd0, 32'd0},
        '{8'h03, 1'b0, 4'd0, 32'd0},
        '{8'h28, 1'b1, 4'd8, 32'd1},
        '{8'h15, 1'b0, 4'd0, 32'd0},
        '{8'h22, 1'b1, 4'd0, 32'd0},
        '{8'h15, 1'b0, 4'd0, 32'd0},
        '{8'h11, 1'b0, 4'd0, 32'd0},
        '{8'hAA, 1'b0, 4'd0, 32'd0},
        '{8'h55, 1'b0, 4'd0, 32'd0},
        '{8'h00, 1'b0, 4'd0, 32'd0},
        '{8'hFF, 1'b0, 4'd0, 32'd0},
        '{8'h10, 1'b0, 4'd0, 32'd0},
        '{8'h20, 1'b0, 4'd0, 32'd0},
        '{8'h30, 1'b0, 4'd0, 32'd0},
        '{8'h40, 1'b0, 4'd0, 32'd0},
        '{8'hC5, 1'b1, 4'd0, 32'd0}
    };

    // advances the parser state by one byte and queues the payload beats of a good frame
    function automatic int track_rx_byte(input logic [7:0] b);
        beat_t bt;
        int n;
        n = 0;
        // a header restarts the frame from any phase
        if (b == hdr_val)
        begin
            ph = PH_TYPE;
            body_cnt = '0;
            run_sum = b;
            return 0;
        end
        case (ph)
            PH_TYPE:
            begin
                if (b == type_val)
                begin
                    run_sum = run_sum + b;
                    ph = PH_BODY;
                end
                else
                begin
                    ph = PH_IDLE;
                end
                body_cnt = '0;
            end
            PH_BODY:
            begin
                if (body_cnt < PAYLOAD_BYTES)
                begin
                    body_store[body_cnt] = b;
                    run_sum = run_sum + b;
                    body_cnt = body_cnt + 7'd1;
                end
                else
                begin
                    if (run_sum == b)
                    begin
                        frames_ok = frames_ok + 32'd1;
                        for (int k = 0; k < PAYLOAD_BYTES; k++)
                        begin
                            bt.data = body_store[k];
                            bt.pos = k[5:0];
                            bt.last = (k == PAYLOAD_BYTES - 1);
                            bt.num = frames_ok;
                            expected_beats.push_back(bt);
                        end
                        n = PAYLOAD_BYTES;
                    end
                    ph = PH_IDLE;
                    body_cnt = '0;
                end
            end
            default:
            begin
                ph = PH_IDLE;
                body_cnt = '0;
            end
        endcase
        return n;
    endfunction

    task automatic send_byte(input logic [7:0] b, output int beats);
        while ($urandom_range(99) < gap_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
        beats = track_rx_byte(b);
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == hdr_val);
        return b;
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] sum;
        logic [7:0] b;
        int n_body;
        int dummy;
        sum = hdr_val + type_val;
        send_byte(hdr_val, dummy);
        if (kind == FR_NOISE)
        begin
            // a short burst of arbitrary bytes, header included only by chance
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(255)), dummy);
            return;
        end
        if (kind == FR_WRONG_TYPE)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == type_val || b == hdr_val);
            send_byte(b, dummy);
            return;
        end
        send_byte(type_val, dummy);
        n_body = (kind == FR_HDR_IN_BODY) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
        for (int i = 0; i < n_body; i++)
        begin
            b = body_byte();
            sum = sum + b;
            send_byte(b, dummy);
        end
        case (kind)
            FR_GOOD:
                send_byte(sum, dummy);
            FR_BAD_SUM:
                send_byte(sum + 8'($urandom_range(1, 255)), dummy);
            default:
                send_byte(hdr_val, dummy);
        endcase
    endtask

    task automatic run_frames(input int n_bytes);
        int stop;
        int r;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 55)
                send_frame(FR_GOOD);
            else if (r < 65)
                send_frame(FR_BAD_SUM);
            else if (r < 73)
                send_frame(FR_WRONG_TYPE);
            else if (r < 81)
                send_frame(FR_HDR_IN_BODY);
            else if (r < 89)
                send_frame(FR_HDR_IN_SUM);
            else
                send_frame(FR_NOISE);
        end
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        // a frame cut short leaves no beat behind, so give the block time to settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] h, input logic [7:0] t);
        cfg_we <= 1'b1;
        cfg_index <= CFG_HEADER;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= CFG_TYPE;
        cfg_data <= t;
        @(posedge clk);
        cfg_we <= 1'b0;
        hdr_val = h;
        type_val = t;
    endtask

    task automatic run_phase(input logic [7:0] h, input logic [7:0] t,
                             input int gap, input int stall);
        wait_idle();
        write_cfg(h, t);
        gap_pct = gap;
        stall_pct = stall;
        run_frames(PHASE_BYTES);
    endtask

    // receiver side: random stalls plus one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : res_check
        beat_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: data %02h pos %0d last %0b frame %0d",
                                 res_ch.payload_byte, res_ch.byte_position,
                                 res_ch.last_byte, res_ch.frame_number);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (res_ch.payload_byte !== want.data || res_ch.byte_position !== want.pos ||
                        res_ch.last_byte !== want.last || res_ch.frame_number !== want.num)
                    begin
                        if (mismatches < 10)
                            $display("beat mismatch: expected %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
                                     want.data, want.pos, want.last, want.num,
                                     res_ch.payload_byte, res_ch.byte_position,
                                     res_ch.last_byte, res_ch.frame_number);
                        mismatches++;
                    end
                end
            end
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int got;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HEADER;
        cfg_data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_cfg(HEADER_RESET, TYPE_RESET);

        for (int i = 0; i < $size(dir_rows); i++)
        begin
            send_byte(dir_rows[i].value, got);
            if (dir_rows[i].typed &&
                (got != dir_rows[i].beats || (got != 0 && frames_ok != dir_rows[i].num)))
            begin
                if (mismatches < 10)
                    $display("row %0d: expected %0d beats of frame %0d, predicted %0d of frame %0d",
                             i, dir_rows[i].beats, dir_rows[i].num, got, frames_ok);
                mismatches++;
            end
        end
        run_frames(PHASE_BYTES);

        // long receiver hold-off while good frames keep coming, so rx backs up
        hold_asked++;
        repeat (3) send_frame(FR_GOOD);

        run_phase(8'h00, 8'hFF, 54, 0);
        run_phase(8'hFF, 8'h00, 0, 54);
        // header equal to type: the type slot always restarts, no frame gets through
        run_phase(8'h5A, 8'h5A, 23, 23);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 0, 0);
        run_phase(HEADER_RESET, TYPE_RESET, 54, 54);

        wait_idle();
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
